// ===== rtl/nopd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nopd_pkg
// Shared constants and types for the neighbour offset pair-delta coder.
// ----------------------------------------------------------------------------
package nopd_pkg;

  // One lane per neighbour offset.
  localparam int unsigned NUM_LANES = 6;
  // Sorted position of one lane, 0..NUM_LANES-1.
  localparam int unsigned RANK_W    = 3;
  // Nonzero count, 0..NUM_LANES.
  localparam int unsigned COUNT_W   = 3;

  typedef logic [RANK_W-1:0]              rank_t;
  typedef rank_t [NUM_LANES-1:0]          rank_vec_t;
  typedef logic [NUM_LANES-1:0]           sign_t;
  typedef logic [COUNT_W-1:0]             count_t;

endpackage

// ===== rtl/neighbour_offset_pair_delta.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_offset_pair_delta
// Sorts six signed neighbour offsets by magnitude and pair-delta codes them.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*): one word carries six signed offsets, offset_0
//   in the lowest bits. Zero marks an absent neighbour.
//   Master channel (m_axis_*): one word per input word with six coded
//   magnitudes, the sign mask and the nonzero count.
//   An accepted word passes the magnitude lane registers and the rank lane
//   registers, then merges into the output register, where it raises
//   m_axis_tvalid_o.
//   Throughput: one word per cycle while not stalled; each stage has its own
//   valid bit and loads whenever it is empty or its successor advances, so
//   bubbles are squeezed out; a word is taken while a finished result waits.
//   Stall: with m_axis_tready_i low the output register holds; the two
//   upstream stages keep filling, then s_axis_tready_o drops.
//   Reset: rst_ni clears every valid bit; the pipe comes up empty and ready.
//   Ties in magnitude keep input order; the most negative input code
//   saturates to the largest magnitude and keeps its sign.
// ----------------------------------------------------------------------------
module neighbour_offset_pair_delta #(
  parameter int unsigned OFFSET_WIDTH = 24,
  parameter int unsigned IN_DATA_W    = ((6 * OFFSET_WIDTH + 7) / 8) * 8,
  parameter int unsigned OUT_DATA_W   = ((6 * (OFFSET_WIDTH - 1) + 9 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // offset_0 .. offset_5, OFFSET_WIDTH bits each, zero fill on top
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // coded_0 .. coded_5 (OFFSET_WIDTH-1 bits each), sign_mask (6),
  // nonzero_count (3), zero fill on top
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  import nopd_pkg::*;

  localparam int unsigned MAG_W   = OFFSET_WIDTH - 1;
  localparam int unsigned CODED_W = NUM_LANES * MAG_W;
  localparam int unsigned PAY_W   = CODED_W + NUM_LANES + COUNT_W;

  // Stage handshakes: a stage loads when empty or when it hands on.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_load, s2_load, out_load;

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign s2_load         = !s2_valid_q  || out_load;
  assign s1_load         = !s1_valid_q  || s2_load;
  assign s_axis_tready_o = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load)  s1_valid_q  <= s_axis_tvalid_i;
      if (s2_load)  s2_valid_q  <= s1_valid_q;
      if (out_load) out_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: one magnitude lane per offset.
  logic [NUM_LANES-1:0][MAG_W-1:0] mag_d, s1_mag_q, s2_mag_q;
  sign_t                           neg_d, s1_neg_q, s2_neg_q;

  // Stage 2: one rank lane per offset, fed from the stage 1 registers.
  rank_vec_t rank_d, s2_rank_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    nopd_mag #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_mag (
      .offset_i(s_axis_tdata_i[l*OFFSET_WIDTH +: OFFSET_WIDTH]),
      .mag_o   (mag_d[l]),
      .neg_o   (neg_d[l])
    );

    nopd_rank #(
      .OFFSET_WIDTH(OFFSET_WIDTH),
      .LANE        (l)
    ) u_rank (
      .mags_i(s1_mag_q),
      .rank_o(rank_d[l])
    );
  end

  // Payload registers advance with their stage and need no reset.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mag_q <= mag_d;
      s1_neg_q <= neg_d;
    end
    if (s2_load) begin
      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_rank_q <= rank_d;
    end
  end

  // Stage 3: merge the lanes into the output register.
  logic [NUM_LANES-1:0][MAG_W-1:0] coded_d, coded_q;
  sign_t                           sign_d, sign_q;
  count_t                          count_d, count_q;

  nopd_merge #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_merge (
    .mags_i     (s2_mag_q),
    .negs_i     (s2_neg_q),
    .ranks_i    (s2_rank_q),
    .coded_o    (coded_d),
    .sign_mask_o(sign_d),
    .count_o    (count_d)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      coded_q <= coded_d;
      sign_q  <= sign_d;
      count_q <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - PAY_W){1'b0}}, count_q, sign_q, coded_q};

  // Rank coverage: every sorted slot is claimed by some lane.
  sign_t rank_cover;

  always_comb begin
    rank_cover = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int p = 0; p < NUM_LANES; p++) begin
        if (s2_rank_q[l] == RANK_W'(p)) rank_cover[p] = 1'b1;
      end
    end
  end

  a_rank_perm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (rank_cover == '1))
    else $error("rank lanes do not form a permutation");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q <= COUNT_W'(NUM_LANES)))
    else $error("nonzero count out of range");

  a_sign_in_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((sign_q >> count_q) == '0))
    else $error("sign bit set beyond nonzero count");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (count_q == '0)) |-> (coded_q == '0))
    else $error("coded data nonzero with zero count");

  a_hold_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_load) |=> (s2_valid_q && $stable(s2_rank_q)))
    else $error("rank stage lost a word under stall");

endmodule

// ===== rtl/nopd_mag.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nopd_mag
// Per-lane sign split: magnitude of one signed offset, saturated so that the
// most negative code still fits in OFFSET_WIDTH-1 bits.
// ----------------------------------------------------------------------------
module nopd_mag #(
  parameter int unsigned OFFSET_WIDTH = 24
) (
  input  logic [OFFSET_WIDTH-1:0] offset_i,
  output logic [OFFSET_WIDTH-2:0] mag_o,
  output logic                    neg_o
);

  logic [OFFSET_WIDTH-1:0] abs_val;

  always_comb begin
    neg_o   = offset_i[OFFSET_WIDTH-1];
    abs_val = neg_o ? (~offset_i + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1}) : offset_i;
    // only the most negative code keeps its top bit after negation
    if (abs_val[OFFSET_WIDTH-1]) begin
      mag_o = '1;
    end else begin
      mag_o = abs_val[OFFSET_WIDTH-2:0];
    end
  end

endmodule

// ===== rtl/nopd_rank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nopd_rank
// Per-lane rank: position of this lane in a stable descending sort of all
// lane magnitudes. Earlier lanes win ties.
// ----------------------------------------------------------------------------
module nopd_rank
#(
  parameter int unsigned OFFSET_WIDTH = 24,
  parameter int unsigned LANE         = 0
) (
  input  logic [nopd_pkg::NUM_LANES-1:0][OFFSET_WIDTH-2:0] mags_i,
  output nopd_pkg::rank_t                                  rank_o
);

  import nopd_pkg::*;

  always_comb begin
    rank_o = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      if (j < LANE) begin
        if (mags_i[j] >= mags_i[LANE]) rank_o = rank_o + RANK_W'(1);
      end else if (j > LANE) begin
        if (mags_i[j] > mags_i[LANE]) rank_o = rank_o + RANK_W'(1);
      end
    end
  end

endmodule

// ===== rtl/nopd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nopd_merge
// Merge stage: scatter lanes to their sorted slots, count nonzero entries,
// swap each complete pair and replace its larger member by the difference.
// ----------------------------------------------------------------------------
module nopd_merge #(
  parameter int unsigned OFFSET_WIDTH = 24
) (
  input  logic [nopd_pkg::NUM_LANES-1:0][OFFSET_WIDTH-2:0] mags_i,
  input  nopd_pkg::sign_t                                  negs_i,
  input  nopd_pkg::rank_vec_t                              ranks_i,
  output logic [nopd_pkg::NUM_LANES-1:0][OFFSET_WIDTH-2:0] coded_o,
  output nopd_pkg::sign_t                                  sign_mask_o,
  output nopd_pkg::count_t                                 count_o
);

  import nopd_pkg::*;

  logic [NUM_LANES-1:0][OFFSET_WIDTH-2:0] sorted_mag;
  sign_t                                  sorted_neg;

  always_comb begin
    sorted_mag = '0;
    sorted_neg = '0;
    count_o    = '0;
    // ranks form a permutation, so an OR of the hits selects one lane
    for (int p = 0; p < NUM_LANES; p++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (ranks_i[l] == RANK_W'(p)) begin
          sorted_mag[p] = sorted_mag[p] | mags_i[l];
          sorted_neg[p] = sorted_neg[p] | negs_i[l];
        end
      end
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (mags_i[l] != '0) count_o = count_o + COUNT_W'(1);
    end

    coded_o     = sorted_mag;
    sign_mask_o = sorted_neg;
    for (int k = 0; k < NUM_LANES / 2; k++) begin
      if (count_o > COUNT_W'(2 * k + 1)) begin
        coded_o[2*k]       = sorted_mag[2*k+1];
        coded_o[2*k+1]     = sorted_mag[2*k] - sorted_mag[2*k+1];
        sign_mask_o[2*k]   = sorted_neg[2*k+1];
        sign_mask_o[2*k+1] = sorted_neg[2*k];
      end
    end
  end

endmodule
